// ===== hdl/mbps_pkg.sv =====
// Shared constants, configuration register codes and the queue entry type
// for the masked byte pattern scanner. No dependencies.
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int BYTE_W      = 8;
  localparam int WIN_W       = MAX_PATTERN * BYTE_W;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int POS_W       = 32;
  localparam int MASK_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_CARE_MASK      = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [LEN_W-1:0] fill;
    logic [POS_W-1:0] pos;
    logic             last;
  } scan_entry_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== hdl/mbps_channels.sv =====
// Valid/ready channel interfaces for the scanner's byte input and result output.
// Depends on mbps_pkg.
interface mbps_in_if
  import mbps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if
  import mbps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== hdl/mbps_front.sv =====
// Front end: accepts image bytes, keeps the byte window, fill and position,
// and pushes one entry per item into the queue. Depends on mbps_pkg, mbps_channels.
module mbps_front
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mbps_in_if.sink      in_ch,
  output hs_t          push_hs,
  input  logic         push_ready,
  output scan_entry_t  push_entry
);

  logic [WIN_W-1:0] win_r, win_nxt, win_shift;
  logic [LEN_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept;

  assign in_ch.ready   = push_ready;
  assign accept        = in_ch.valid && push_ready;
  assign push_hs.valid = in_ch.valid;
  assign push_hs.ready = push_ready;

  assign win_shift = {win_r[WIN_W-BYTE_W-1:0], in_ch.data_byte};
  assign fill_inc  = (fill_r == LEN_W'(MAX_PATTERN)) ? fill_r : fill_r + 1'b1;

  assign push_entry.window = win_shift;
  assign push_entry.fill   = fill_inc;
  assign push_entry.pos    = pos_r;
  assign push_entry.last   = in_ch.last_byte;

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        win_nxt  = '0;
        fill_nxt = '0;
        pos_nxt  = '0;
      end else begin
        win_nxt  = win_shift;
        fill_nxt = fill_inc;
        pos_nxt  = (&pos_r) ? pos_r : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
      pos_r  <= '0;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ===== hdl/mbps_queue.sv =====
// Two-entry queue that decouples the front end from the compare stage.
// Depends on mbps_pkg.
module mbps_queue
  import mbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  scan_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop_ready,
  output scan_entry_t pop_entry
);

  scan_entry_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/mbps_back.sv =====
// Back end: holds the configuration registers, compares each queued window
// with the masked pattern and registers the result item. Depends on mbps_pkg, mbps_channels.
module mbps_back
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  scan_entry_t           pop_entry,
  mbps_out_if.source            out_ch
);

  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [MASK_W-1:0]     care_r;
  logic [LEN_W-1:0]      plen_r;

  logic                  done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [POS_W-1:0]      out_offset_r;

  logic [LEN_W-1:0]      len_eff, len_m1;
  logic [WIN_W-1:0]      pattern;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic                  match;
  logic                  do_pop, emit, emit_found;
  logic [POS_W-1:0]      offset;

  assign pattern = {pat_high_r, pat_low_r};

  always_comb begin
    if (plen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = plen_r;
    end
  end

  assign len_m1 = len_eff - 1'b1;

  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len_m1 - LEN_W'(k);
      byte_ok[k] = (LEN_W'(k) >= len_eff) || !care_r[k] ||
                   (pop_entry.window[idx[IDX_W-1:0]*BYTE_W +: BYTE_W] ==
                    pattern[k*BYTE_W +: BYTE_W]);
    end
  end

  assign match  = (pop_entry.fill >= len_eff) && (&byte_ok);
  assign offset = pop_entry.pos - {{(POS_W-LEN_W){1'b0}}, len_m1};

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    done_nxt   = done_r;
    emit       = 1'b0;
    emit_found = 1'b0;
    if (do_pop) begin
      if (done_r) begin
        if (pop_entry.last) begin
          done_nxt = 1'b0;
        end
      end else if (match) begin
        emit       = 1'b1;
        emit_found = 1'b1;
        done_nxt   = !pop_entry.last;
      end else if (pop_entry.last) begin
        emit = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found_r  <= emit_found;
      out_offset_r <= emit_found ? offset : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      care_r      <= '0;
      plen_r      <= LEN_W'(1);
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_PATTERN_LOW:    pat_low_r  <= cfg_wdata;
          CFG_PATTERN_HIGH:   pat_high_r <= cfg_wdata;
          CFG_CARE_MASK:      care_r     <= cfg_wdata[MASK_W-1:0];
          CFG_PATTERN_LENGTH: plen_r     <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offset_r;

endmodule

// ===== hdl/masked_byte_pattern_scanner_core.sv =====
// Top level of the masked byte pattern scanner: front end, queue and back end.
// Depends on mbps_pkg, mbps_channels, mbps_front, mbps_queue, mbps_back.
//
//   port    | direction | carries
//   --------+-----------+-------------------------------------------
//   in_ch   | sink      | data_byte, last_byte (one image byte per item)
//   out_ch  | source    | found, match_offset (at most one per image)
//   cfg_*   | write     | cfg_index selects register, cfg_wdata value
//
// One item is accepted per cycle while the queue has room; the item that causes
// a result passes through the queue entry register and then the result register.
// While a result waits on a stalled output the back end stops, and the
// two-entry queue takes up to two more items before the input stalls.
// Reset is synchronous and active low; it clears the window, the counters,
// the pattern, the care mask and all valid flags, and sets the pattern length to 1.
module masked_byte_pattern_scanner_core
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mbps_in_if.sink               in_ch,
  mbps_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hs_t         push_hs;
  logic        push_ready;
  scan_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  scan_entry_t pop_entry;

  mbps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_hs    (push_hs),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  mbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_hs.valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

  a_accept_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (push_hs.valid && push_hs.ready))
    else $error("Accepted item was not pushed into the queue.");

  a_nomatch_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.match_offset == '0))
    else $error("Result without a match carries a nonzero offset.");

  a_reset_no_result: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("Result valid right after reset.");

endmodule
